// ===== sv/awfs_pkg.sv =====
// Shared types and constants of the acknowledged frame sender.
package awfs_pkg;

  localparam int PROTOCOL_BITS_DEF = 24;
  localparam int TICK_W = 16;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;
  localparam int M_TDATA_W = 8;

  typedef enum logic [2:0] {
    MODE_STEP       = 3'd0,
    MODE_SEND       = 3'd1,
    MODE_ACK        = 3'd2,
    MODE_READ       = 3'd3,
    MODE_READ_PROTO = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_BUSY      = 3'd1,
    ST_OK        = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_PROTO_ERR = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_TXWAIT  = 3'b010,
    PH_ACKWAIT = 3'b100
  } phase_t;

  typedef struct packed {
    mode_t mode;
    logic  uart_busy;
    logic  needs_ack;
  } item_ctrl_t;

  // Packed so that status sits in the lowest bits.
  typedef struct packed {
    logic    start_tx;
    logic    rejected;
    status_t status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

// ===== sv/awfs_in_reg.sv =====
// Input register: holds one accepted request and unpacks its fields.
module awfs_in_reg
  import awfs_pkg::*;
#(
  parameter int PROTOCOL_BITS = PROTOCOL_BITS_DEF,
  parameter int S_TDATA_W     = ((PROTOCOL_BITS + 2 + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [S_TDATA_W-1:0]     s_axis_tdata,
  input  logic [2:0]               s_axis_tuser,
  input  logic                     advance,
  output logic                     item_valid,
  output item_ctrl_t               item_ctrl,
  output logic [PROTOCOL_BITS-1:0] item_protocol
);

  logic valid;

  assign s_axis_tready = !valid || advance;
  assign item_valid    = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_ctrl.mode      <= mode_t'(s_axis_tuser);
      item_ctrl.uart_busy <= s_axis_tdata[0];
      item_ctrl.needs_ack <= s_axis_tdata[PROTOCOL_BITS+1];
      item_protocol       <= s_axis_tdata[PROTOCOL_BITS:1];
    end
  end

endmodule

// ===== sv/awfs_core.sv =====
// Sender state, acknowledgement timer and timeout register; one request per cycle when advance is high.
module awfs_core
  import awfs_pkg::*;
#(
  parameter int PROTOCOL_BITS = PROTOCOL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TICK_W-1:0]        cfg_data,
  input  logic                     advance,
  input  item_ctrl_t               item_ctrl,
  input  logic [PROTOCOL_BITS-1:0] item_protocol,
  output result_t                  result
);

  logic [TICK_W-1:0]        timeout_ticks;
  phase_t                   phase, phase_next;
  status_t                  status_reg, status_reg_next;
  logic                     send_pending, send_pending_next;
  logic                     ack_pending, ack_pending_next;
  logic [PROTOCOL_BITS-1:0] sent_protocol, sent_protocol_next;
  logic                     sent_needs_ack, sent_needs_ack_next;
  logic [PROTOCOL_BITS-1:0] ack_protocol, ack_protocol_next;
  logic [TICK_W-1:0]        wait_ticks, wait_ticks_next;
  logic [TICK_W-1:0]        wait_inc;
  logic                     rejected;
  logic                     start_tx;

  assign cfg_ready = 1'b1;
  assign wait_inc  = (wait_ticks != TICK_MAX) ? wait_ticks + 1'b1 : wait_ticks;

  always_comb begin
    phase_next          = phase;
    status_reg_next     = status_reg;
    send_pending_next   = send_pending;
    ack_pending_next    = ack_pending;
    sent_protocol_next  = sent_protocol;
    sent_needs_ack_next = sent_needs_ack;
    ack_protocol_next   = ack_protocol;
    wait_ticks_next     = wait_ticks;
    rejected            = 1'b0;
    start_tx            = 1'b0;
    unique case (item_ctrl.mode)
      MODE_STEP: begin
        unique case (phase)
          PH_TXWAIT: begin
            if (!item_ctrl.uart_busy) begin
              if (!sent_needs_ack) begin
                status_reg_next = ST_IDLE;
                phase_next      = PH_IDLE;
              end else begin
                wait_ticks_next = '0;
                phase_next      = PH_ACKWAIT;
              end
            end
          end
          PH_ACKWAIT: begin
            if (ack_pending) begin
              ack_pending_next = 1'b0;
              status_reg_next  = (ack_protocol == sent_protocol) ? ST_OK : ST_PROTO_ERR;
              phase_next       = PH_IDLE;
            end else begin
              wait_ticks_next = wait_inc;
              if (wait_inc >= timeout_ticks) begin
                status_reg_next = ST_TIMEOUT;
                phase_next      = PH_IDLE;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
            if (send_pending) begin
              send_pending_next = 1'b0;
              start_tx          = 1'b1;
              phase_next        = PH_TXWAIT;
            end
          end
        endcase
      end
      MODE_SEND: begin
        if (status_reg == ST_BUSY) begin
          rejected = 1'b1;
        end else begin
          send_pending_next   = 1'b1;
          sent_protocol_next  = item_protocol;
          sent_needs_ack_next = item_ctrl.needs_ack;
          status_reg_next     = ST_BUSY;
        end
      end
      MODE_ACK: begin
        ack_protocol_next = item_protocol;
        ack_pending_next  = 1'b1;
      end
      MODE_READ: begin
        if (status_reg != ST_BUSY) begin
          status_reg_next = ST_IDLE;
        end
      end
      MODE_READ_PROTO: begin
        if (status_reg != ST_BUSY && sent_protocol == item_protocol) begin
          status_reg_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.status   = status_reg;
  assign result.rejected = rejected;
  assign result.start_tx = start_tx;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      status_reg     <= ST_IDLE;
      send_pending   <= 1'b0;
      ack_pending    <= 1'b0;
      sent_protocol  <= '0;
      sent_needs_ack <= 1'b0;
      ack_protocol   <= '0;
      wait_ticks     <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      status_reg     <= status_reg_next;
      send_pending   <= send_pending_next;
      ack_pending    <= ack_pending_next;
      sent_protocol  <= sent_protocol_next;
      sent_needs_ack <= sent_needs_ack_next;
      ack_protocol   <= ack_protocol_next;
      wait_ticks     <= wait_ticks_next;
    end
  end

endmodule

// ===== sv/awfs_out_reg.sv =====
// Result register on the master side of the stream.
module awfs_out_reg
  import awfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  result_t              result,
  output logic                 can_load,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic    valid;
  result_t held;

  assign can_load      = !valid || m_axis_tready;
  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= result;
    end
  end

endmodule

// ===== sv/ack_wait_frame_sender.sv =====
// Stop-and-wait frame sender with acknowledgement timeout: top level.
// Every request on the slave stream (step tick, send, ack, status read, status read
// with protocol) yields exactly one result on the master stream carrying the status
// as it was before the request, a refusal flag for sends made while busy, and the
// start_tx pulse. A request is held in the input register and its answer is then
// loaded into the result register, from which it is presented on the master side;
// with the master side ready the block takes one request every cycle, the rate being
// set by the state update between the two registers. A stalled master side holds
// its result, and once both registers are full the slave side stops taking
// requests. timeout_ticks is written on the cfg channel (reset 1000) and should
// change only while no request is in flight.
module ack_wait_frame_sender
  import awfs_pkg::*;
#(
  parameter int PROTOCOL_BITS = PROTOCOL_BITS_DEF,
  parameter int S_TDATA_W     = ((PROTOCOL_BITS + 2 + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TICK_W-1:0]    cfg_data,       // timeout_ticks
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // uart_busy, protocol, needs_ack, zero pad
  input  logic [2:0]           s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // status, rejected, start_tx, zero pad
);

  logic                     item_valid;
  item_ctrl_t               item_ctrl;
  logic [PROTOCOL_BITS-1:0] item_protocol;
  logic                     can_load;
  logic                     advance;
  result_t                  result;

  // Advance the held request when the result register can take its answer.
  assign advance = item_valid && can_load;

  awfs_in_reg #(
    .PROTOCOL_BITS (PROTOCOL_BITS),
    .S_TDATA_W     (S_TDATA_W)
  ) u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (advance),
    .item_valid    (item_valid),
    .item_ctrl     (item_ctrl),
    .item_protocol (item_protocol)
  );

  awfs_core #(
    .PROTOCOL_BITS (PROTOCOL_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .advance       (advance),
    .item_ctrl     (item_ctrl),
    .item_protocol (item_protocol),
    .result        (result)
  );

  awfs_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (item_valid),
    .result        (result),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== sv/awfs_checker.sv =====
// Port-level checks on the sender's result stream, bound to the top level.
module awfs_checker
  import awfs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result must hold.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A refused send can only be seen while the status is busy.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2:0] == ST_BUSY)
    else $error("send refused with status not busy");

  // Starting a transmission implies an accepted send left the status busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[2:0] == ST_BUSY)
    else $error("start_tx with status not busy");

  // A refusal and a start never come from the same request.
  a_reject_start: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("rejected and start_tx both set");

endmodule

bind ack_wait_frame_sender awfs_checker u_awfs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
